// ===== rtl/abrs_pkg.sv =====
// abrs_pkg: shared widths, controller state and command/status types
// for the aligned block range splitter. No dependencies.
`timescale 1ns / 1ps

package abrs_pkg;

   localparam int DEFAULT_ADDR_WIDTH = 32;
   localparam int START_WIDTH        = 32;
   localparam int END_WIDTH          = 33;
   localparam int LOG2_WIDTH         = 6;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } ctrl_state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;   // capture a new range
      logic step;   // emit one block into the output register
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic last;   // the block that step would emit ends the range
   } dp_status_type;

endpackage

// ===== rtl/abrs_datapath.sv =====
// abrs_datapath: cursor / remaining-length registers, block size selection
// and the result payload register. Depends on abrs_pkg.
`timescale 1ns / 1ps

module abrs_datapath #(
   parameter int ADDR_WIDTH = abrs_pkg::DEFAULT_ADDR_WIDTH
) (
   input  logic                            clock,
   input  abrs_pkg::dp_cmd_type            cmd,
   output abrs_pkg::dp_status_type         status,
   input  logic [abrs_pkg::START_WIDTH-1:0] range_start,
   input  logic [abrs_pkg::END_WIDTH-1:0]   range_end,
   output logic [abrs_pkg::START_WIDTH-1:0] block_start,
   output logic [abrs_pkg::LOG2_WIDTH-1:0]  block_log2_size,
   output logic                             last_block,
   output logic                             empty_range
);
   import abrs_pkg::*;

   localparam int KW = $clog2(ADDR_WIDTH + 1);

   logic [ADDR_WIDTH-1:0] cursor_ff, cursor_in;
   logic [ADDR_WIDTH:0]   rem_ff, rem_in;
   logic                  empty_ff, empty_in;

   logic [START_WIDTH-1:0] start_ff;
   logic [LOG2_WIDTH-1:0]  lg_ff;
   logic                   last_ff, empty_out_ff;

   logic [END_WIDTH-1:0]  span;
   logic [END_WIDTH-1:0]  end_clamped;
   logic [END_WIDTH-1:0]  start_ext;
   logic                  range_is_empty;
   logic [KW-1:0]         tz;
   logic [KW-1:0]         msb;
   logic [KW-1:0]         k;
   logic [ADDR_WIDTH:0]   pow;

   // range clamp at load
   always_comb begin
      span           = END_WIDTH'(1) << ADDR_WIDTH;
      end_clamped    = (range_end > span) ? span : range_end;
      start_ext      = END_WIDTH'(range_start[ADDR_WIDTH-1:0]);
      range_is_empty = (start_ext >= end_clamped);
   end

   // trailing zeros of cursor (alignment) and msb of remaining length
   always_comb begin
      tz = KW'(ADDR_WIDTH);
      for (int i = ADDR_WIDTH - 1; i >= 0; i--) begin
         if (cursor_ff[i]) tz = KW'(i);
      end
      msb = '0;
      for (int j = 0; j <= ADDR_WIDTH; j++) begin
         if (rem_ff[j]) msb = KW'(j);
      end
      k   = (tz < msb) ? tz : msb;
      pow = (ADDR_WIDTH + 1)'(1) << k;
   end

   assign status.last = empty_ff || (rem_ff == pow);

   always_comb begin
      cursor_in = cursor_ff;
      rem_in    = rem_ff;
      empty_in  = empty_ff;
      if (cmd.load) begin
         cursor_in = range_start[ADDR_WIDTH-1:0];
         empty_in  = range_is_empty;
         rem_in    = range_is_empty ? '0
                   : (ADDR_WIDTH + 1)'(end_clamped - start_ext);
      end else if (cmd.step) begin
         cursor_in = cursor_ff + pow[ADDR_WIDTH-1:0];
         rem_in    = rem_ff - pow;
      end
   end

   always_ff @(posedge clock) begin
      cursor_ff <= cursor_in;
      rem_ff    <= rem_in;
      empty_ff  <= empty_in;
      if (cmd.step) begin
         start_ff     <= START_WIDTH'(cursor_ff);
         lg_ff        <= empty_ff ? '0 : LOG2_WIDTH'(k);
         last_ff      <= status.last;
         empty_out_ff <= empty_ff;
      end
   end

   assign block_start     = start_ff;
   assign block_log2_size = lg_ff;
   assign last_block      = last_ff;
   assign empty_range     = empty_out_ff;

endmodule

// ===== rtl/abrs_ctrl.sv =====
// abrs_ctrl: handshake controller; sequences load and one step per block
// and owns the result valid flag. Depends on abrs_pkg.
`timescale 1ns / 1ps

module abrs_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output abrs_pkg::dp_cmd_type    cmd,
   input  abrs_pkg::dp_status_type status
);
   import abrs_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           slot_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      slot_free    = !rsp_valid_ff || rsp_ready;
      req_ready    = 1'b0;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (slot_free) begin
               cmd.step     = 1'b1;
               rsp_valid_in = 1'b1;
               if (status.last) state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/aligned_block_range_splitter.sv =====
// Aligned block range splitter: tiles [start, end) with aligned power-of-two blocks.
// A range is captured first, then one block per cycle moves into the
// output register while it is free or being drained; a range yields n blocks
// (n <= 2*ADDR_WIDTH-2). That block rate is set by the single block-select unit.
// Reset (synchronous, active high) returns the controller to idle, no beat pending.
`timescale 1ns / 1ps

module aligned_block_range_splitter #(
   parameter int ADDR_WIDTH = abrs_pkg::DEFAULT_ADDR_WIDTH
) (
   input  logic                              clock,
   input  logic                              reset,
   // range request channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [abrs_pkg::START_WIDTH-1:0]  req_range_start,
   input  logic [abrs_pkg::END_WIDTH-1:0]    req_range_end,
   // block result channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [abrs_pkg::START_WIDTH-1:0]  rsp_block_start,
   output logic [abrs_pkg::LOG2_WIDTH-1:0]   rsp_block_log2_size,
   output logic                              rsp_last_block,
   output logic                              rsp_empty_range
);
   import abrs_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // The controller accepts a range only when idle. While running, it
   // issues one step per cycle in which the output register is free or
   // being drained, so a waiting result never blocks the next block
   // computation for more than the stall itself. After the final block is
   // loaded the controller is idle again and may take the next range while
   // that final beat still waits downstream.
   abrs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   // Datapath: block size = min(alignment of cursor, floor log2 of the
   // remaining length). An empty range yields one beat with empty and last set.
   abrs_datapath #(
      .ADDR_WIDTH (ADDR_WIDTH)
   ) u_datapath (
      .clock           (clock),
      .cmd             (cmd),
      .status          (status),
      .range_start     (req_range_start),
      .range_end       (req_range_end),
      .block_start     (rsp_block_start),
      .block_log2_size (rsp_block_log2_size),
      .last_block      (rsp_last_block),
      .empty_range     (rsp_empty_range)
   );

endmodule

// ===== rtl/abrs_checker.sv =====
// abrs_checker: port-level assertions for the aligned block range splitter,
// attached by bind. Depends on abrs_pkg.
`timescale 1ns / 1ps

module abrs_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic [abrs_pkg::START_WIDTH-1:0]  req_range_start,
   input logic [abrs_pkg::END_WIDTH-1:0]    req_range_end,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [abrs_pkg::START_WIDTH-1:0]  rsp_block_start,
   input logic [abrs_pkg::LOG2_WIDTH-1:0]   rsp_block_log2_size,
   input logic                              rsp_last_block,
   input logic                              rsp_empty_range
);
   import abrs_pkg::*;

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_block_start)
         && $stable(rsp_block_log2_size) && $stable(rsp_last_block)
         && $stable(rsp_empty_range))
      else $error("stalled result beat changed");

   // an empty range is a single, zero-size, final beat
   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty_range |-> rsp_last_block && (rsp_block_log2_size == '0))
      else $error("empty beat without last flag or with nonzero size");

   // blocks are naturally aligned
   a_aligned: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_empty_range |->
         (((64'(rsp_block_start) >> rsp_block_log2_size) << rsp_block_log2_size)
            == 64'(rsp_block_start)))
      else $error("block start not aligned to its size");

   // a taken non-final beat is followed at once by the next block
   a_next_block: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_block |=> rsp_valid)
      else $error("gap in block stream");

   // an accepted range keeps the request side closed on the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while a range is in progress");

endmodule

bind aligned_block_range_splitter abrs_checker u_abrs_checker (.*);
